>>> hdl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants for the quaternion vector rotation block: default
// widths and the configuration register indexes.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROTOR_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTOR_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTOR_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTOR_Z = 2'd3;

endpackage

>>> hdl/quaternion_vector_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a signed fixed-point 3D vector by the configured rotor using the
// normalized conjugate; saturates the result and flags a zero-length rotor.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         tvalid/tready      tdata = in_x, in_y, in_z
//  m_*       out        tvalid/tready      tdata = out_x, out_y, out_z;
//                                          tuser = saturated, degenerate
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
// One vector enters per cycle while s_tready is high; a request passes the p1,
// t, p2 and res registers. After reset and after every register write, a
// sequencer recomputes the normalized conjugate: the sum of the four squares, a
// bit-serial square root and 4 divisions; s_tready stays low during that time.
// A stalled output holds the last stage; earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation
  import qvr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [DATA_WIDTH-1:0]             cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // in_x, in_y, in_z from the lowest bit up, zero padded to bytes
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_x, out_y, out_z from the lowest bit up, zero padded to bytes
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // saturated, degenerate from the lowest bit up
  output logic [1:0]                        m_tuser
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int TDW  = ((3*W+7)/8)*8;
  localparam int PW   = 2*W;
  localparam int TSW  = 2*W+2;
  localparam int TW   = TSW-F;
  localparam int CW   = F+2;
  localparam int P2W  = TW+CW;
  localparam int RSW  = P2W+2;
  localparam int RW   = RSW-F;
  localparam int SW   = 2*W+1;
  localparam int SSW  = 2*W+2;
  localparam int RTW  = W+1;
  localparam int RMW  = W+3;
  localparam int NW   = W+F+2;
  localparam int MW   = W+F+1;
  localparam int DVW  = W+2;
  localparam int DRW  = W+3;
  localparam int CNT_W = $clog2(MW+1);

  localparam logic signed [TSW-1:0] HALF_T = {{(TSW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [RSW-1:0] HALF_R = {{(RSW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [W-1:0] ONE_Q = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [W-1:0] MAX_Q = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_Q = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {ST_SQ, ST_ROOT, ST_LOAD, ST_DIV, ST_DONE} seq_state_t;

  // Rotor registers
  logic signed [W-1:0] rot [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= ONE_Q;
      rot[1] <= '0;
      rot[2] <= '0;
      rot[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTOR_W: rot[0] <= cfg_data;
        REG_ROTOR_X: rot[1] <= cfg_data;
        REG_ROTOR_Y: rot[2] <= cfg_data;
        REG_ROTOR_Z: rot[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Normalization sequencer
  seq_state_t          state;
  logic [1:0]          idx;
  logic [CNT_W-1:0]    cnt;
  logic [SW-1:0]       s_acc;
  logic [SSW-1:0]      s_src;
  logic [RMW-1:0]      sq_rem;
  logic [RTW-1:0]      root;
  logic [RTW-1:0]      len;
  logic [MW-1:0]       div_m;
  logic [DRW-1:0]      div_rem;
  logic [MW-1:0]       div_q;
  logic [DVW-1:0]      dvs;
  logic                div_neg;
  logic                degen;
  logic signed [CW-1:0] c [4];

  logic signed [PW-1:0] sq_prod;
  logic [SW-1:0]        s_sum;
  logic [RMW-1:0]       sq_sh;
  logic [RMW-1:0]       sq_trial;
  logic                 sq_ge;
  logic [RTW-1:0]       root_next;
  logic signed [NW-1:0] num_n;
  logic [DVW-1:0]       dvs_c;
  logic [NW-1:0]        mag_n;
  logic [DRW-1:0]       dv_sh;
  logic                 dv_ge;
  logic [MW-1:0]        q_fin;
  logic signed [CW-1:0] q_c;

  always_comb begin
    sq_prod   = rot[idx] * rot[idx];
    s_sum     = s_acc + {1'b0, sq_prod[PW-1:0]};
    sq_sh     = {sq_rem[RMW-3:0], s_src[SSW-1:SSW-2]};
    sq_trial  = {root, 2'b01};
    sq_ge     = (sq_sh >= sq_trial);
    root_next = {root[RTW-2:0], sq_ge};
    dvs_c     = {len, 1'b0};
    num_n     = $signed({rot[idx][W-1], rot[idx], {(F+1){1'b0}}}) +
                $signed({{(NW-RTW){1'b0}}, len});
    // Floor division of a negative numerator rounds its magnitude up.
    if (num_n[NW-1]) begin
      mag_n = -num_n + {{(NW-DVW){1'b0}}, dvs_c} - {{(NW-1){1'b0}}, 1'b1};
    end else begin
      mag_n = num_n;
    end
    dv_sh = {div_rem[DRW-2:0], div_m[MW-1]};
    dv_ge = (dv_sh >= {1'b0, dvs});
    q_fin = {div_q[MW-2:0], dv_ge};
    q_c   = $signed(q_fin[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= ST_SQ;
      idx   <= '0;
      s_acc <= '0;
      cnt   <= '0;
      degen <= 1'b0;
    end else begin
      case (state)
        ST_SQ: begin
          s_acc <= s_sum;
          idx   <= idx + 2'd1;
          if (idx == 2'd3) begin
            s_src  <= {1'b0, s_sum};
            sq_rem <= '0;
            root   <= '0;
            cnt    <= '0;
            state  <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          sq_rem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          root   <= root_next;
          s_src  <= {s_src[SSW-3:0], 2'b00};
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(W)) begin
            len <= root_next;
            idx <= '0;
            if (s_acc == '0) begin
              degen <= 1'b1;
              c[0]  <= '0;
              c[1]  <= '0;
              c[2]  <= '0;
              c[3]  <= '0;
              state <= ST_DONE;
            end else begin
              degen <= 1'b0;
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          dvs     <= dvs_c;
          div_m   <= mag_n[MW-1:0];
          div_neg <= num_n[NW-1];
          div_rem <= '0;
          div_q   <= '0;
          cnt     <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_rem <= dv_ge ? (dv_sh - {1'b0, dvs}) : dv_sh;
          div_m   <= {div_m[MW-2:0], 1'b0};
          div_q   <= q_fin;
          cnt     <= cnt + 1'b1;
          if (cnt == CNT_W'(MW-1)) begin
            // The scalar part keeps its sign; the vector parts are conjugated.
            c[idx] <= (div_neg ^ (idx != 2'd0)) ? -q_c : q_c;
            idx    <= idx + 2'd1;
            state  <= (idx == 2'd3) ? ST_DONE : ST_LOAD;
          end
        end
        ST_DONE: ;
        default: state <= ST_SQ;
      endcase
    end
  end

  // Rotation pipeline
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !v4 || m_tready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = (state == ST_DONE) && adv1;

  logic signed [W-1:0] vin [3];
  assign vin[0] = $signed(s_tdata[W-1:0]);
  assign vin[1] = $signed(s_tdata[2*W-1:W]);
  assign vin[2] = $signed(s_tdata[3*W-1:2*W]);

  logic signed [PW-1:0]  p1 [12];
  logic signed [TSW-1:0] tsum [4];
  logic signed [TW-1:0]  t [4];
  logic signed [P2W-1:0] p2 [12];
  logic signed [RSW-1:0] rsum [3];
  logic signed [RW-1:0]  r [3];
  logic [W-1:0]          out_v [3];
  logic [2:0]            clip;
  logic [W-1:0]          res [3];
  logic                  res_sat;
  logic                  res_degen;

  always_comb begin
    tsum[0] = -p1[0] - p1[1] - p1[2];
    tsum[1] =  p1[3] + p1[4] - p1[5];
    tsum[2] =  p1[6] + p1[7] - p1[8];
    tsum[3] =  p1[9] + p1[10] - p1[11];
    for (int k = 0; k < 4; k++) begin
      tsum[k] = tsum[k] + HALF_T;
    end
    rsum[0] = p2[0] + p2[1] + p2[2]  - p2[3];
    rsum[1] = p2[4] + p2[5] + p2[6]  - p2[7];
    rsum[2] = p2[8] + p2[9] + p2[10] - p2[11];
    for (int k = 0; k < 3; k++) begin
      rsum[k] = rsum[k] + HALF_R;
      r[k]    = rsum[k][RSW-1:F];
      clip[k] = (r[k][RW-1:W-1] != '0) && (r[k][RW-1:W-1] != '1);
      if (!clip[k]) begin
        out_v[k] = r[k][W-1:0];
      end else if (r[k][RW-1]) begin
        out_v[k] = MIN_Q;
      end else begin
        out_v[k] = MAX_Q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid && s_tready;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      p1[0]  <= rot[1] * vin[0];
      p1[1]  <= rot[2] * vin[1];
      p1[2]  <= rot[3] * vin[2];
      p1[3]  <= rot[0] * vin[0];
      p1[4]  <= rot[2] * vin[2];
      p1[5]  <= rot[3] * vin[1];
      p1[6]  <= rot[0] * vin[1];
      p1[7]  <= rot[3] * vin[0];
      p1[8]  <= rot[1] * vin[2];
      p1[9]  <= rot[0] * vin[2];
      p1[10] <= rot[1] * vin[1];
      p1[11] <= rot[2] * vin[0];
    end
    if (adv2) begin
      for (int k = 0; k < 4; k++) begin
        t[k] <= tsum[k][TSW-1:F];
      end
    end
    if (adv3) begin
      p2[0]  <= t[0] * c[1];
      p2[1]  <= t[1] * c[0];
      p2[2]  <= t[2] * c[3];
      p2[3]  <= t[3] * c[2];
      p2[4]  <= t[0] * c[2];
      p2[5]  <= t[2] * c[0];
      p2[6]  <= t[3] * c[1];
      p2[7]  <= t[1] * c[3];
      p2[8]  <= t[0] * c[3];
      p2[9]  <= t[3] * c[0];
      p2[10] <= t[1] * c[2];
      p2[11] <= t[2] * c[1];
    end
    if (adv4) begin
      res[0]    <= out_v[0];
      res[1]    <= out_v[1];
      res[2]    <= out_v[2];
      res_sat   <= |clip;
      res_degen <= degen;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {{(TDW-3*W){1'b0}}, res[2], res[1], res[0]};
  assign m_tuser  = {res_degen, res_sat};

  // A zero rotor drives all conjugate parts to zero, so its results are zero.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("degenerate result is not zero");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("request taken while rotor is being renormalized");

  a_ready_done: assert property (@(posedge clk)
    s_tready |-> (state == ST_DONE))
    else $error("ready raised before normalization finished");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    v4 && !m_tready |=> v4 && $stable(res[0]) && $stable(res_sat))
    else $error("stalled result lost");

endmodule
